### hdl/kfs_pkg.sv
package kfs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PC_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYS = 3'd0,
		CFG_IO  = 3'd1,
		CFG_PN  = 3'd2,
		CFG_RN  = 3'd3,
		CFG_IC  = 3'd4
	} cfg_idx_t;

	typedef enum logic [5:0] {
		R_X0 = 6'd0, R_X1, R_P00, R_P01, R_P10, R_P11,
		R_XH0, R_XH1, R_AP00, R_AP01, R_AP10, R_AP11,
		R_PH00, R_PH01, R_PH10, R_PH11, R_CX, R_E, R_PHC0, R_PHC1, R_S,
		R_K0, R_K1, R_M00, R_M01, R_M10, R_M11, R_BU0, R_BU1,
		K_ZERO = 6'd32, K_ONE, K_MONE, K_ONEF,
		K_A00, K_A01, K_A10, K_A11, K_B0, K_B1, K_C0, K_C1,
		K_Q00, K_Q01, K_Q10, K_Q11, K_RF, K_U, K_Y
	} opnd_t;

	typedef enum logic [1:0] {SH_Q12, SH_FRAC, SH_NONE} shift_t;
	typedef enum logic {UOP_MAC, UOP_DIV} uop_kind_t;

	typedef struct packed {
		uop_kind_t kind;
		opnd_t     dst;
		opnd_t     a;
		opnd_t     b;
		opnd_t     c;
		opnd_t     d;
		opnd_t     add;
		shift_t    sh;
		logic      neg;
	} uop_t;

	localparam logic [PC_W-1:0] PC_DIV0 = 5'd17;
	localparam logic [PC_W-1:0] PC_LAST = 5'd28;

	typedef struct packed {
		logic   load_in;
		logic   rd_en;
		opnd_t  addr_a;
		opnd_t  addr_b;
		logic   mul_en;
		logic   acc_en;
		logic   sum_en;
		logic   wr_en;
		logic   div_start;
		logic   div_wr;
		opnd_t  wr_addr;
		shift_t sh;
		logic   neg;
		logic   clr_rst;
		logic   out_ld;
		logic   sing;
	} cmd_t;

	typedef struct packed {
		logic s_zero;
		logic div_done;
		logic out_busy;
	} sts_t;

	function automatic uop_t mk(input uop_kind_t kind, input opnd_t dst, input opnd_t a,
			input opnd_t b, input opnd_t c, input opnd_t d, input opnd_t add,
			input shift_t sh, input logic neg);
		uop_t u;
		u.kind = kind;
		u.dst = dst;
		u.a = a;
		u.b = b;
		u.c = c;
		u.d = d;
		u.add = add;
		u.sh = sh;
		u.neg = neg;
		return u;
	endfunction

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0: u = mk(UOP_MAC, R_BU0, K_B0, K_U, K_ZERO, K_ZERO, K_ZERO, SH_Q12, 1'b0);
			5'd1: u = mk(UOP_MAC, R_BU1, K_B1, K_U, K_ZERO, K_ZERO, K_ZERO, SH_Q12, 1'b0);
			5'd2: u = mk(UOP_MAC, R_XH0, K_A00, R_X0, K_A01, R_X1, R_BU0, SH_Q12, 1'b0);
			5'd3: u = mk(UOP_MAC, R_XH1, K_A10, R_X0, K_A11, R_X1, R_BU1, SH_Q12, 1'b0);
			5'd4: u = mk(UOP_MAC, R_AP00, K_A00, R_P00, K_A01, R_P10, K_ZERO, SH_Q12, 1'b0);
			5'd5: u = mk(UOP_MAC, R_AP01, K_A00, R_P01, K_A01, R_P11, K_ZERO, SH_Q12, 1'b0);
			5'd6: u = mk(UOP_MAC, R_AP10, K_A10, R_P00, K_A11, R_P10, K_ZERO, SH_Q12, 1'b0);
			5'd7: u = mk(UOP_MAC, R_AP11, K_A10, R_P01, K_A11, R_P11, K_ZERO, SH_Q12, 1'b0);
			5'd8: u = mk(UOP_MAC, R_PH00, R_AP00, K_A00, R_AP01, K_A01, K_Q00, SH_Q12, 1'b0);
			5'd9: u = mk(UOP_MAC, R_PH01, R_AP00, K_A10, R_AP01, K_A11, K_Q01, SH_Q12, 1'b0);
			5'd10: u = mk(UOP_MAC, R_PH10, R_AP10, K_A00, R_AP11, K_A01, K_Q10, SH_Q12, 1'b0);
			5'd11: u = mk(UOP_MAC, R_PH11, R_AP10, K_A10, R_AP11, K_A11, K_Q11, SH_Q12, 1'b0);
			5'd12: u = mk(UOP_MAC, R_CX, K_C0, R_XH0, K_C1, R_XH1, K_ZERO, SH_Q12, 1'b0);
			5'd13: u = mk(UOP_MAC, R_E, K_Y, K_ONE, R_CX, K_MONE, K_ZERO, SH_NONE, 1'b0);
			5'd14: u = mk(UOP_MAC, R_PHC0, R_PH00, K_C0, R_PH01, K_C1, K_ZERO, SH_Q12, 1'b0);
			5'd15: u = mk(UOP_MAC, R_PHC1, R_PH10, K_C0, R_PH11, K_C1, K_ZERO, SH_Q12, 1'b0);
			5'd16: u = mk(UOP_MAC, R_S, K_C0, R_PHC0, K_C1, R_PHC1, K_RF, SH_Q12, 1'b0);
			5'd17: u = mk(UOP_DIV, R_K0, R_PHC0, K_ZERO, K_ZERO, K_ZERO, K_ZERO, SH_NONE, 1'b0);
			5'd18: u = mk(UOP_DIV, R_K1, R_PHC1, K_ZERO, K_ZERO, K_ZERO, K_ZERO, SH_NONE, 1'b0);
			5'd19: u = mk(UOP_MAC, R_X0, R_K0, R_E, K_ZERO, K_ZERO, R_XH0, SH_FRAC, 1'b0);
			5'd20: u = mk(UOP_MAC, R_X1, R_K1, R_E, K_ZERO, K_ZERO, R_XH1, SH_FRAC, 1'b0);
			5'd21: u = mk(UOP_MAC, R_M00, R_K0, K_C0, K_ZERO, K_ZERO, K_ONEF, SH_Q12, 1'b1);
			5'd22: u = mk(UOP_MAC, R_M01, R_K0, K_C1, K_ZERO, K_ZERO, K_ZERO, SH_Q12, 1'b1);
			5'd23: u = mk(UOP_MAC, R_M10, R_K1, K_C0, K_ZERO, K_ZERO, K_ZERO, SH_Q12, 1'b1);
			5'd24: u = mk(UOP_MAC, R_M11, R_K1, K_C1, K_ZERO, K_ZERO, K_ONEF, SH_Q12, 1'b1);
			5'd25: u = mk(UOP_MAC, R_P00, R_M00, R_PH00, R_M01, R_PH10, K_ZERO, SH_FRAC, 1'b0);
			5'd26: u = mk(UOP_MAC, R_P01, R_M00, R_PH01, R_M01, R_PH11, K_ZERO, SH_FRAC, 1'b0);
			5'd27: u = mk(UOP_MAC, R_P10, R_M10, R_PH00, R_M11, R_PH10, K_ZERO, SH_FRAC, 1'b0);
			5'd28: u = mk(UOP_MAC, R_P11, R_M10, R_PH01, R_M11, R_PH11, K_ZERO, SH_FRAC, 1'b0);
			default: u = mk(UOP_MAC, R_BU0, K_ZERO, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
				SH_NONE, 1'b0);
		endcase
		return u;
	endfunction

endpackage

### hdl/kfs_div.sv
module kfs_div #(
	parameter int FRAC_BITS = kfs_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	import kfs_pkg::*;

	localparam int QW = 32 + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] nmag_q;
	logic [QW-1:0] q_q;
	logic [31:0]   rem_q;
	logic [31:0]   dmag_q;
	logic          neg_q;
	logic          done_q;
	logic [31:0]   quo_q;
	logic [32:0]   trial;
	logic          fits;
	logic [31:0]   num_mag;
	logic [31:0]   den_mag;
	logic          hi_any;

	assign num_mag = num[31] ? 32'(-num) : num;
	assign den_mag = den[31] ? 32'(-den) : den;
	assign trial = {rem_q, nmag_q[QW-1]};
	assign fits = trial >= {1'b0, dmag_q};
	assign hi_any = |q_q[QW-1:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nmag_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dmag_q <= den_mag;
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			nmag_q <= {nmag_q[QW-2:0], 1'b0};
			q_q <= {q_q[QW-2:0], fits};
			rem_q <= fits ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
		end else if (busy_q) begin
			if (neg_q) begin
				if (hi_any || (q_q[31] && |q_q[30:0]))
					quo_q <= 32'h8000_0000;
				else
					quo_q <= 32'(-q_q[31:0]);
			end else begin
				if (hi_any || q_q[31])
					quo_q <= 32'h7FFF_FFFF;
				else
					quo_q <= q_q[31:0];
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

### hdl/kfs_dp.sv
module kfs_dp #(
	parameter int FRAC_BITS = kfs_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [31:0]                 control_input,
	input  logic signed [31:0]                 measurement,
	input  kfs_pkg::cmd_t                      cmd,
	output kfs_pkg::sts_t                      sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [31:0]                 estimate_first,
	output logic signed [31:0]                 estimate_second,
	output logic                               singular
);
	import kfs_pkg::*;

	localparam int UP = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
	localparam int DN = (FRAC_BITS >= 12) ? 0 : 12 - FRAC_BITS;

	logic [63:0] sys_q, io_q, pn_q, ic_q;
	logic [15:0] rn_q;
	logic        rst_q;
	logic [31:0] u_q, y_q;
	logic [31:0] mem [0:31];
	logic [31:0] rda_q, rdb_q;
	logic [31:0] ka, kb, ra, rb;
	logic signed [63:0] prod_q, acc_q, prod_sh;
	logic [31:0] t_q, s_q;
	logic signed [64:0] sum65;
	logic signed [33:0] fin34;
	logic [31:0] alu;
	logic        div_done;
	logic [31:0] quo;
	logic        out_valid_q;
	logic [31:0] est0_q, est1_q;
	logic        sing_q;

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] tf(input logic [31:0] v);
		logic signed [31:0] e;
		e = $signed(v);
		return (e <<< UP) >>> DN;
	endfunction

	function automatic logic [31:0] kval(input opnd_t code, input logic [63:0] sys,
			input logic [63:0] io, input logic [63:0] pn, input logic [15:0] rn,
			input logic [31:0] u, input logic [31:0] y);
		logic [31:0] r;
		case (code)
			K_ONE:   r = 32'd1;
			K_MONE:  r = '1;
			K_ONEF:  r = 32'd1 << FRAC_BITS;
			K_A00:   r = ext16(sys[15:0]);
			K_A01:   r = ext16(sys[31:16]);
			K_A10:   r = ext16(sys[47:32]);
			K_A11:   r = ext16(sys[63:48]);
			K_B0:    r = ext16(io[15:0]);
			K_B1:    r = ext16(io[31:16]);
			K_C0:    r = ext16(io[47:32]);
			K_C1:    r = ext16(io[63:48]);
			K_Q00:   r = tf(ext16(pn[15:0]));
			K_Q01:   r = tf(ext16(pn[31:16]));
			K_Q10:   r = tf(ext16(pn[47:32]));
			K_Q11:   r = tf(ext16(pn[63:48]));
			K_RF:    r = tf({16'd0, rn});
			K_U:     r = u;
			K_Y:     r = y;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rval(input opnd_t code, input logic [63:0] ic);
		logic [31:0] r;
		case (code)
			R_P00:   r = tf(ext16(ic[15:0]));
			R_P01:   r = tf(ext16(ic[31:16]));
			R_P10:   r = tf(ext16(ic[47:32]));
			R_P11:   r = tf(ext16(ic[63:48]));
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat65(input logic signed [64:0] v);
		if (!v[64] && |v[63:31])
			return 32'h7FFF_FFFF;
		else if (v[64] && !(&v[63:31]))
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] sat34(input logic signed [33:0] v);
		if (!v[33] && |v[32:31])
			return 32'h7FFF_FFFF;
		else if (v[33] && !(&v[32:31]))
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	always_comb begin
		ka = kval(cmd.addr_a, sys_q, io_q, pn_q, rn_q, u_q, y_q);
		kb = kval(cmd.addr_b, sys_q, io_q, pn_q, rn_q, u_q, y_q);
		ra = rval(cmd.addr_a, ic_q);
		rb = rval(cmd.addr_b, ic_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q <= '0;
			io_q <= '0;
			pn_q <= '0;
			rn_q <= '0;
			ic_q <= '0;
			rst_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYS: begin
						sys_q <= cfg_data;
						rst_q <= 1'b1;
					end
					CFG_IO: begin
						io_q <= cfg_data;
						rst_q <= 1'b1;
					end
					CFG_PN: begin
						pn_q <= cfg_data;
						rst_q <= 1'b1;
					end
					CFG_RN: begin
						rn_q <= cfg_data[15:0];
						rst_q <= 1'b1;
					end
					CFG_IC: begin
						ic_q <= cfg_data;
						rst_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (cmd.clr_rst) begin
				rst_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			u_q <= control_input;
			y_q <= measurement;
		end
		if (cmd.wr_en)
			mem[cmd.wr_addr[4:0]] <= alu;
		else if (cmd.div_wr)
			mem[cmd.wr_addr[4:0]] <= quo;
		if (cmd.rd_en) begin
			if (cmd.addr_a[5])
				rda_q <= ka;
			else if (rst_q && cmd.addr_a <= R_P11)
				rda_q <= ra;
			else
				rda_q <= mem[cmd.addr_a[4:0]];
			if (cmd.addr_b[5])
				rdb_q <= kb;
			else if (rst_q && cmd.addr_b <= R_P11)
				rdb_q <= rb;
			else
				rdb_q <= mem[cmd.addr_b[4:0]];
		end
		if (cmd.mul_en)
			prod_q <= $signed(rda_q) * $signed(rdb_q);
		if (cmd.acc_en)
			acc_q <= prod_sh;
		if (cmd.sum_en)
			t_q <= sat65(sum65);
	end

	always_comb begin
		case (cmd.sh)
			SH_Q12:  prod_sh = prod_q >>> 12;
			SH_FRAC: prod_sh = prod_q >>> FRAC_BITS;
			default: prod_sh = prod_q;
		endcase
		sum65 = {acc_q[63], acc_q} + {prod_sh[63], prod_sh};
		if (cmd.neg)
			fin34 = {{2{rda_q[31]}}, rda_q} - {{2{t_q[31]}}, t_q};
		else
			fin34 = {{2{rda_q[31]}}, rda_q} + {{2{t_q[31]}}, t_q};
		alu = sat34(fin34);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_en && cmd.wr_addr == R_S)
				s_q <= alu;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			est0_q <= rda_q;
			est1_q <= rdb_q;
			sing_q <= cmd.sing;
		end
	end

	kfs_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(rda_q),
		.den(s_q),
		.done(div_done),
		.quo(quo)
	);

	assign sts.s_zero = (s_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign estimate_first = est0_q;
	assign estimate_second = est1_q;
	assign singular = sing_q;

endmodule

### hdl/kfs_ctrl.sv
module kfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          busy,
	input  kfs_pkg::sts_t sts,
	output kfs_pkg::cmd_t cmd
);
	import kfs_pkg::*;

	typedef enum logic [3:0] {
		IDLE, READ, MUL1, MUL2, SUM, WRITE, DIV_GO, DIV_WAIT, OUT_RD, OUT_LD
	} state_t;

	state_t          state;
	logic [PC_W-1:0] pc_q;
	logic            sing_q;
	uop_t            u;

	assign u = uop_rom(pc_q);
	assign busy = (state != IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state <= IDLE;
			pc_q <= '0;
			sing_q <= 1'b0;
		end else begin
			case (state)
				IDLE: begin
					if (in_valid) begin
						pc_q <= '0;
						sing_q <= 1'b0;
						state <= READ;
					end
				end
				READ: begin
					if (pc_q == PC_DIV0 && sts.s_zero) begin
						sing_q <= 1'b1;
						state <= OUT_RD;
					end else if (u.kind == UOP_DIV) begin
						state <= DIV_GO;
					end else begin
						state <= MUL1;
					end
				end
				MUL1: state <= MUL2;
				MUL2: state <= SUM;
				SUM: state <= WRITE;
				WRITE: begin
					if (pc_q == PC_LAST) begin
						state <= OUT_RD;
					end else begin
						pc_q <= pc_q + PC_W'(1);
						state <= READ;
					end
				end
				DIV_GO: state <= DIV_WAIT;
				DIV_WAIT: begin
					if (sts.div_done) begin
						pc_q <= pc_q + PC_W'(1);
						state <= READ;
					end
				end
				OUT_RD: state <= OUT_LD;
				OUT_LD: begin
					if (!sts.out_busy)
						state <= IDLE;
				end
				default: state <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.addr_a = K_ZERO;
		cmd.addr_b = K_ZERO;
		cmd.wr_addr = u.dst;
		cmd.sh = u.sh;
		cmd.neg = u.neg;
		cmd.sing = sing_q;
		case (state)
			IDLE: cmd.load_in = in_valid;
			READ: begin
				cmd.rd_en = 1'b1;
				cmd.addr_a = u.a;
				cmd.addr_b = u.b;
			end
			MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.addr_a = u.c;
				cmd.addr_b = u.d;
			end
			MUL2: begin
				cmd.acc_en = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.addr_a = u.add;
			end
			SUM: cmd.sum_en = 1'b1;
			WRITE: begin
				cmd.wr_en = 1'b1;
				cmd.clr_rst = (pc_q == PC_LAST);
			end
			DIV_GO: cmd.div_start = 1'b1;
			DIV_WAIT: cmd.div_wr = sts.div_done;
			OUT_RD: begin
				cmd.rd_en = 1'b1;
				cmd.addr_a = R_X0;
				cmd.addr_b = R_X1;
			end
			OUT_LD: cmd.out_ld = !sts.out_busy;
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_singular_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state == READ && pc_q == PC_DIV0 && sts.s_zero) |=> (state == OUT_RD && sing_q))
		else $error("zero innovation variance did not skip the update");
	a_commit_nonsingular: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_rst |-> !sing_q)
		else $error("covariance committed on a singular step");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state == DIV_WAIT && !sts.div_done) |=> state == DIV_WAIT)
		else $error("left divide wait before quotient ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state == OUT_LD && sts.out_busy) |=> state == OUT_LD)
		else $error("result dropped while output register busy");
`endif

endmodule

### hdl/kalman_filter_step.sv
// Two-state Kalman filter step in signed Q(32-FRAC_BITS).FRAC_BITS: each accepted beat
// (control_input, measurement) runs predict and update and returns one result beat with both
// state estimates and a singular flag. One item runs 27 multiply-accumulate steps through
// one shared 32x32 multiplier and scratch memory, two restoring gain divisions, an accept
// state and the output read and load states; a singular step ends after the innovation
// variance. A new input beat is taken while the previous result still waits on out_stall.
// Any configuration write to a listed register clears the estimate and reloads the
// covariance from initial_covariance; write configuration only while the block is idle.
module kalman_filter_step #(
	parameter int FRAC_BITS = kfs_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [31:0]             control_input,
	input  logic signed [31:0]             measurement,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             estimate_first,
	output logic signed [31:0]             estimate_second,
	output logic                           singular
);
	import kfs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;

	kfs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.busy(busy),
		.sts(sts),
		.cmd(cmd)
	);

	kfs_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.control_input(control_input),
		.measurement(measurement),
		.cmd(cmd),
		.sts(sts),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.estimate_first(estimate_first),
		.estimate_second(estimate_second),
		.singular(singular)
	);

endmodule

### bench/kalman_filter_step_tb.sv
`timescale 1ns / 100ps

module kalman_filter_step_tb;
	import kfs_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [31:0] est0;
		logic signed [31:0] est1;
		logic               sing;
	} estimate_t;

	class kalman_scoreboard;
		logic [63:0] sys_m, io_m, pn_m, rn_m, ic_m;
		longint xe[2];
		longint pc[2][2];
		estimate_t pending_q[$];

		function longint sat(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function longint q12(logic [63:0] r, int k);
			return longint'($signed(r[16*k +: 16]));
		endfunction

		function longint to_fb(longint c);
			return sat((c <<< FB) >>> 12);
		endfunction

		function void restart();
			for (int i = 0; i < 2; i++) begin
				xe[i] = 0;
				for (int j = 0; j < 2; j++)
					pc[i][j] = to_fb(q12(ic_m, i * 2 + j));
			end
		endfunction

		function void power_up();
			sys_m = '0;
			io_m = '0;
			pn_m = '0;
			rn_m = '0;
			ic_m = '0;
			pending_q.delete();
			restart();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_SYS: sys_m = data;
				CFG_IO: io_m = data;
				CFG_PN: pn_m = data;
				CFG_RN: rn_m = {48'd0, data[15:0]};
				CFG_IC: ic_m = data;
				default: return;
			endcase
			restart();
		endfunction

		function void note_input(logic signed [31:0] u_in, logic signed [31:0] y_in);
			longint a[2][2], b[2], c[2], xh[2], ap[2][2], ph[2][2], phc[2], k[2], m[2][2];
			longint u, y, cx, e, s, rf, apa, kc, one;
			estimate_t r;
			u = longint'(u_in);
			y = longint'(y_in);
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++)
					a[i][j] = q12(sys_m, i * 2 + j);
				b[i] = q12(io_m, i);
				c[i] = q12(io_m, 2 + i);
			end
			rf = to_fb(longint'(rn_m[15:0]));
			for (int i = 0; i < 2; i++)
				xh[i] = sat(sat(((a[i][0] * xe[0]) >>> 12) + ((a[i][1] * xe[1]) >>> 12))
					+ sat((b[i] * u) >>> 12));
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					ap[i][j] = sat(((a[i][0] * pc[0][j]) >>> 12) + ((a[i][1] * pc[1][j]) >>> 12));
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++) begin
					apa = sat(((ap[i][0] * a[j][0]) >>> 12) + ((ap[i][1] * a[j][1]) >>> 12));
					ph[i][j] = sat(apa + to_fb(q12(pn_m, i * 2 + j)));
				end
			cx = sat(((c[0] * xh[0]) >>> 12) + ((c[1] * xh[1]) >>> 12));
			e = sat(y - cx);
			for (int i = 0; i < 2; i++)
				phc[i] = sat(((ph[i][0] * c[0]) >>> 12) + ((ph[i][1] * c[1]) >>> 12));
			s = sat(sat(((c[0] * phc[0]) >>> 12) + ((c[1] * phc[1]) >>> 12)) + rf);
			r.sing = (s == 0);
			if (s != 0) begin
				for (int i = 0; i < 2; i++)
					k[i] = sat((phc[i] <<< FB) / s);
				for (int i = 0; i < 2; i++)
					xe[i] = sat(xh[i] + sat((k[i] * e) >>> FB));
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++) begin
						kc = sat((k[i] * c[j]) >>> 12);
						one = (i == j) ? (64'sd1 <<< FB) : 0;
						m[i][j] = sat(one - kc);
					end
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++)
						pc[i][j] = sat(((m[i][0] * ph[0][j]) >>> FB)
							+ ((m[i][1] * ph[1][j]) >>> FB));
			end
			r.est0 = xe[0][31:0];
			r.est1 = xe[1][31:0];
			pending_q.push_back(r);
		endfunction

		function string check_result(logic signed [31:0] e0, logic signed [31:0] e1,
				logic sg);
			estimate_t w;
			string msg;
			msg = "";
			if (pending_q.size() == 0)
				return "result beat with no estimate pending";
			w = pending_q.pop_front();
			if (e0 !== w.est0)
				msg = {msg, $sformatf(" estimate_first %0d want %0d", e0, w.est0)};
			if (e1 !== w.est1)
				msg = {msg, $sformatf(" estimate_second %0d want %0d", e1, w.est1)};
			if (sg !== w.sing)
				msg = {msg, $sformatf(" singular %0b want %0b", sg, w.sing)};
			return msg;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] control_input = '0;
	logic signed [31:0] measurement = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] estimate_first;
	logic signed [31:0] estimate_second;
	logic singular;

	kalman_scoreboard sb;
	int errors = 0;
	int results_seen = 0;
	bit long_hold = 1'b0;
	bit quiet = 1'b0;

	kalman_filter_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.control_input(control_input),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.estimate_first(estimate_first),
		.estimate_second(estimate_second),
		.singular(singular)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// result side: random stall per beat, one long hold on request
	initial begin
		int n;
		string msg;
		sb = new();
		sb.power_up();
		forever begin
			n = quiet ? 0 : $urandom_range(0, 4);
			if (long_hold) begin
				n = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_seen++;
			msg = sb.check_result(estimate_first, estimate_second, singular);
			if (msg != "")
				report(msg);
		end
	end

	task automatic send_beat(logic signed [31:0] u, logic signed [31:0] y);
		int n;
		n = quiet ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		control_input <= u;
		measurement <= y;
		do @(posedge clk); while (in_stall);
		sb.note_input(u, y);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() > 0);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic load_filter(logic [63:0] sys, logic [63:0] io, logic [63:0] pn,
			logic [63:0] rn, logic [63:0] ic);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_SYS, sys);
		write_reg(CFG_IO, io);
		write_reg(CFG_PN, pn);
		write_reg(CFG_RN, rn);
		write_reg(CFG_IC, ic);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pack4(int e0, int e1, int e2, int e3);
		return {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
	endfunction

	function automatic int spread(int n);
		return int'($urandom_range(0, 2 * n)) - n;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(spread(1 << 20));
			2: return 32'(spread(1 << 26));
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic load_tracker();
		load_filter(pack4(16'h1000 + spread(64), spread(512), spread(64),
				16'h1000 - $urandom_range(0, 256)),
			pack4(spread(4096), spread(4096), 16'h1000 + spread(256), spread(256)),
			pack4($urandom_range(1, 64), 0, 0, $urandom_range(1, 64)),
			64'($urandom_range(0, 8192)),
			pack4($urandom_range(0, 16'h4000), 0, 0, $urandom_range(0, 16'h4000)));
	endtask

	initial begin
		logic [31:0] edges[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
		logic [63:0] ext;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero registers after reset: innovation variance is zero
		send_beat(32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(32'h0, 32'hFFFF_FFFF);

		load_filter(pack4(16'h1000, 16'h0100, 0, 16'h1000), pack4(16'h0080, 16'h1000,
			16'h1000, 0), pack4(16'h0010, 0, 0, 16'h0010), 64'h1000,
			pack4(16'h1000, 0, 0, 16'h1000));
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 3; j++)
				send_beat(edges[i], edges[(i + j + 1) % 5]);

		// negative process noise drives the innovation variance below zero
		load_filter(pack4(16'h1000, 0, 0, 16'h1000), pack4(0, 0, 16'h1000, 16'h1000),
			pack4(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000), 64'h0,
			pack4(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
		for (int i = 0; i < 4; i++)
			send_beat(edges[i], edges[4 - i]);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: load_tracker();
				1: load_filter({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
				2: begin
					ext = (ph == 2) ? {4{16'h7FFF}} : {4{16'h8000}};
					load_filter(ext, ext, ext, (ph == 2) ? 64'hFFFF : 64'h0, ext);
				end
				default: load_filter(pack4(spread(8192), spread(8192), spread(8192),
						spread(8192)),
					pack4(spread(4096), spread(4096), $urandom_range(0, 1) ? spread(4096) : 0,
						$urandom_range(0, 1) ? spread(4096) : 0),
					pack4(spread(256), spread(256), spread(256), spread(256)),
					64'($urandom_range(0, 1) ? $urandom_range(0, 16'hFFFF) : 0),
					pack4(spread(8192), spread(8192), spread(8192), spread(8192)));
			endcase
			quiet = (ph == 5);
			for (int n = 0; n < 215; n++) begin
				if (ph == 2 && n == 20)
					long_hold = 1'b1;
				if (ph == 4 && n == 100) begin
					drain();
					repeat (SETTLE_CYCLES) @(posedge clk);
					// unused index: no effect, no restart
					write_reg(CFG_UNUSED, {$urandom, $urandom});
					cfg_valid <= 1'b0;
				end
				send_beat(rand_word(), rand_word());
			end
		end
		quiet = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
